// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is applied.
`define CRPI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CRPI_ASSERT_NEXT(label, ante, cons, msg) \
	`CRPI_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- src/crpi_pkg.sv -----
// Types and constants of the Catmull-Rom point interpolator.
package crpi_pkg;

	localparam int COORD_W = 32;
	localparam int PIDX_W  = 6;
	localparam int T_W     = 17;
	localparam int CFG_W   = 7;
	// Horner accumulator width: holds every coefficient and partial sum
	localparam int H_W     = 40;
	localparam int PT_W    = 3 * COORD_W;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic                      mode;
		logic [PIDX_W-1:0]         point_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [T_W-1:0]            param_t;
	} crpi_cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      saturated;
	} crpi_result_t;

endpackage

// ----- src/catmull_rom_point_interpolator.sv -----
// Top level: point table, sequencer and Horner datapath of the spline evaluator.
//
// Load items (mode 0) write one x/y/z control point in the cycle they are
// accepted and never raise busy. An evaluate item (mode 1) holds busy until
// its result is registered, and the result strobe done rises in the same
// cycle that busy falls; with point_count of one the sequencer skips the
// scaling and Horner steps. A new item may be started in the cycle that
// done is high. The time is set by one shared multiplier of about
// 21 x (FRAC_BITS+2) bits: per axis three Horner steps, each built from two
// half-width partial products, plus four single-port reads of the point table.
// Results are held, but done is high for one cycle only; the receiver must
// take them when done is high. Configuration writes are taken while busy is low.
module catmull_rom_point_interpolator
	import crpi_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  crpi_cmd_t        cmd,
	output logic             done,
	output crpi_result_t     result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IDX_W = (AW > PIDX_W) ? AW : PIDX_W;
	localparam int NC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int U_W   = FRAC_BITS + 1;
	localparam int TC_W  = (U_W > T_W) ? U_W : T_W;
	localparam int G_W   = COORD_W + 2;
	localparam int LO_W  = H_W / 2;
	localparam int MA_W  = LO_W + 1;
	localparam int MB_W  = U_W + 1;
	localparam int P_W   = MA_W + MB_W;
	localparam int ACC_W = H_W + U_W + 1;
	localparam int ONE   = 1 << FRAC_BITS;
	localparam int HALF  = 1 << (FRAC_BITS - 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCALE  = 4'd1;
	localparam logic [3:0] ST_SPLIT  = 4'd2;
	localparam logic [3:0] ST_READ   = 4'd3;
	localparam logic [3:0] ST_COEF   = 4'd4;
	localparam logic [3:0] ST_LO     = 4'd5;
	localparam logic [3:0] ST_HI     = 4'd6;
	localparam logic [3:0] ST_ACC    = 4'd7;
	localparam logic [3:0] ST_RND    = 4'd8;
	localparam logic [3:0] ST_FIN    = 4'd9;
	localparam logic [3:0] ST_SINGLE = 4'd10;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	// slots of the four fetched points, in read order
	localparam logic [1:0] PT_P1 = 2'd0;
	localparam logic [1:0] PT_P2 = 2'd1;
	localparam logic [1:0] PT_P0 = 2'd2;
	localparam logic [1:0] PT_P3 = 2'd3;

	localparam logic [2:0] RD_LAST   = 3'd4;
	localparam logic [1:0] STEP_LAST = 2'd2;

	function automatic logic signed [COORD_W-1:0] axis_sel(input logic [PT_W-1:0] p,
		input logic [1:0] ax);
		logic signed [COORD_W-1:0] v;
		case (ax)
			AX_X: v = p[3*COORD_W-1 -: COORD_W];
			AX_Y: v = p[2*COORD_W-1 -: COORD_W];
			default: v = p[COORD_W-1:0];
		endcase
		return v;
	endfunction

	// control state
	logic [3:0]       state_q;
	logic [2:0]       rd_cnt_q;
	logic [1:0]       ax_q;
	logic [1:0]       step_q;
	logic             done_q;
	logic             single_q;
	logic [CFG_W-1:0] point_count_q;

	// datapath registers
	logic [CNT_W-1:0]        n_q;
	logic [U_W-1:0]          u_q;
	logic [AW-1:0]           seg_q;
	logic                    ghost0_q;
	logic                    ghost3_q;
	logic signed [H_W-1:0]   h_q;
	logic signed [H_W-1:0]   coef_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [PT_W-1:0]         pt_q [4];
	crpi_result_t            res_q;

	// point table
	logic [PT_W-1:0] mem_q [MAX_POINTS];
	logic [PT_W-1:0] rdata_q;
	logic [AW-1:0]   rd_addr;

	logic             xfer;
	logic             eval_go;
	logic             load_wr;
	logic [IDX_W-1:0] idx_ext;
	logic [AW-1:0]    wr_addr;
	logic [NC_W-1:0]  cnt_ext;
	logic [CNT_W-1:0] n_next;
	logic [TC_W-1:0]  t_ext;
	logic [U_W-1:0]   t_cl;

	logic [CNT_W-1:0]           nm1;
	logic [CNT_W-1:0]           nm2;
	logic [CNT_W-1:0]           seg_raw;
	logic [CNT_W-1:0]           seg_cap;
	logic [FRAC_BITS+CNT_W-1:0] scl_lo;
	logic [FRAC_BITS+CNT_W-1:0] scl_diff;
	logic [U_W-1:0]             u_new;
	logic                       ghost3;
	logic [1:0]                 pt_wi;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  mul_prod;

	logic signed [G_W-1:0] v0, v1, v2, v3;
	logic signed [H_W-1:0] w0, w1, w2, w3, d12;
	logic signed [H_W-1:0] coef_a, coef_b, coef_c, coef_d;

	logic signed [H_W-1:0]     h_inc;
	logic signed [H_W-1:0]     h_half;
	logic                      ovf;
	logic signed [COORD_W-1:0] r_sat;

	// input transfer and table write
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy;
	assign xfer      = start & ~busy;
	assign eval_go   = xfer & (cmd.mode == MODE_EVAL);
	assign idx_ext   = IDX_W'(cmd.point_index);
	assign wr_addr   = idx_ext[AW-1:0];
	assign load_wr   = xfer & (cmd.mode == MODE_LOAD)
		& ({1'b0, idx_ext} < (IDX_W + 1)'(MAX_POINTS));

	// clamp the point count and the parameter
	assign cnt_ext = NC_W'(point_count_q);
	always_comb begin
		if (cnt_ext == '0) begin
			n_next = CNT_W'(1);
		end else if (cnt_ext > NC_W'(MAX_POINTS)) begin
			n_next = CNT_W'(MAX_POINTS);
		end else begin
			n_next = CNT_W'(cnt_ext);
		end
	end
	assign t_ext = TC_W'(cmd.param_t);
	assign t_cl  = (t_ext > TC_W'(ONE)) ? U_W'(ONE) : U_W'(t_ext);

	// split t * (n - 1) into segment and fraction
	assign nm1      = n_q - CNT_W'(1);
	assign nm2      = n_q - CNT_W'(2);
	assign seg_raw  = mul_prod[FRAC_BITS +: CNT_W];
	assign seg_cap  = (seg_raw > nm2) ? nm2 : seg_raw;
	assign scl_lo   = mul_prod[FRAC_BITS+CNT_W-1:0];
	assign scl_diff = scl_lo - {seg_cap, {FRAC_BITS{1'b0}}};
	assign u_new    = scl_diff[U_W-1:0];
	assign ghost3   = ({1'b0, seg_cap} + (CNT_W + 1)'(2)) >= {1'b0, n_q};

	// read address per fetch slot; a ghost slot rereads a real neighbor
	always_comb begin
		case (rd_cnt_q[1:0])
			PT_P1: rd_addr = seg_q;
			PT_P2: rd_addr = seg_q + AW'(1);
			PT_P0: rd_addr = ghost0_q ? seg_q : seg_q - AW'(1);
			default: rd_addr = ghost3_q ? seg_q + AW'(1) : seg_q + AW'(2);
		endcase
	end
	assign pt_wi = 2'(rd_cnt_q - 3'd1);

	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem_q[wr_addr] <= {cmd.coord_x, cmd.coord_y, cmd.coord_z};
		end
		rdata_q <= mem_q[rd_addr];
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_b = $signed({1'b0, u_q});
		case (state_q)
			ST_SCALE: mul_a = $signed(MA_W'(nm1));
			ST_LO:    mul_a = $signed({1'b0, h_q[LO_W-1:0]});
			ST_HI:    mul_a = MA_W'($signed(h_q[H_W-1:LO_W]));
			default:  mul_a = '0;
		endcase
	end

	crpi_mul #(
		.A_W(MA_W),
		.B_W(MB_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(mul_prod)
	);

	// current axis of the four points, with mirrored ghosts at the ends
	assign v1 = G_W'(axis_sel(pt_q[PT_P1], ax_q));
	assign v2 = G_W'(axis_sel(pt_q[PT_P2], ax_q));
	assign v0 = ghost0_q ? (v1 <<< 1) - v2 : G_W'(axis_sel(pt_q[PT_P0], ax_q));
	assign v3 = ghost3_q ? (v2 <<< 1) - v1 : G_W'(axis_sel(pt_q[PT_P3], ax_q));
	assign w0 = H_W'(v0);
	assign w1 = H_W'(v1);
	assign w2 = H_W'(v2);
	assign w3 = H_W'(v3);

	// cubic coefficients
	assign d12    = w1 - w2;
	assign coef_a = (w3 - w0) + (d12 <<< 1) + d12;
	assign coef_b = ((w0 - w1) <<< 1) - ((d12 <<< 1) + d12) + (w2 - w3);
	assign coef_c = w2 - w0;
	assign coef_d = w1 <<< 1;

	// halve with rounding and clip to the coordinate range
	assign h_inc  = h_q + H_W'(1);
	assign h_half = h_inc >>> 1;
	assign ovf    = ~((&h_half[H_W-1:COORD_W-1]) | ~(|h_half[H_W-1:COORD_W-1]));
	assign r_sat  = ovf ? (h_half[H_W-1] ? COORD_MIN : COORD_MAX) : h_half[COORD_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_cnt_q      <= '0;
			ax_q          <= AX_X;
			step_q        <= '0;
			done_q        <= 1'b0;
			single_q      <= 1'b0;
			point_count_q <= CFG_W'(1);
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				point_count_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (eval_go) begin
						single_q <= (n_next == CNT_W'(1));
						rd_cnt_q <= '0;
						state_q  <= (n_next == CNT_W'(1)) ? ST_READ : ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= ST_READ;
				ST_READ: begin
					if (rd_cnt_q == RD_LAST) begin
						ax_q    <= AX_X;
						state_q <= single_q ? ST_SINGLE : ST_COEF;
					end else begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end
				end
				ST_COEF: begin
					step_q  <= '0;
					state_q <= ST_LO;
				end
				ST_LO:  state_q <= ST_HI;
				ST_HI:  state_q <= ST_ACC;
				ST_ACC: state_q <= ST_RND;
				ST_RND: begin
					step_q  <= step_q + 2'd1;
					state_q <= (step_q == STEP_LAST) ? ST_FIN : ST_LO;
				end
				ST_FIN: begin
					if (ax_q == AX_Z) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_COEF;
					end
				end
				ST_SINGLE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (eval_go) begin
			n_q               <= n_next;
			u_q               <= t_cl;
			seg_q             <= '0;
			ghost0_q          <= 1'b1;
			ghost3_q          <= 1'b1;
			res_q.saturated   <= 1'b0;
		end
		case (state_q)
			ST_SPLIT: begin
				seg_q    <= AW'(seg_cap);
				u_q      <= u_new;
				ghost0_q <= (seg_cap == '0);
				ghost3_q <= ghost3;
			end
			ST_READ: begin
				if (rd_cnt_q != '0) begin
					pt_q[pt_wi] <= rdata_q;
				end
			end
			ST_COEF: begin
				h_q    <= coef_a;
				coef_q <= coef_b;
			end
			// low partial product plus the rounding half
			ST_HI: acc_q <= ACC_W'(mul_prod) + ACC_W'(HALF);
			// add the high partial product
			ST_ACC: acc_q <= acc_q + (ACC_W'(mul_prod) <<< LO_W);
			ST_RND: begin
				h_q    <= H_W'(acc_q >>> FRAC_BITS) + coef_q;
				coef_q <= (step_q == '0) ? coef_c : coef_d;
			end
			ST_FIN: begin
				case (ax_q)
					AX_X: res_q.out_x <= r_sat;
					AX_Y: res_q.out_y <= r_sat;
					default: res_q.out_z <= r_sat;
				endcase
				if (ovf) begin
					res_q.saturated <= 1'b1;
				end
			end
			ST_SINGLE: begin
				res_q.out_x <= axis_sel(pt_q[PT_P1], AX_X);
				res_q.out_y <= axis_sel(pt_q[PT_P1], AX_Y);
				res_q.out_z <= axis_sel(pt_q[PT_P1], AX_Z);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- src/crpi_mul.sv -----
// Shared signed multiplier with a registered product.
module crpi_mul #(
	parameter int A_W = 21,
	parameter int B_W = 18
) (
	input  logic                      clk,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [B_W-1:0]     b,
	output logic signed [A_W+B_W-1:0] prod
);

	logic signed [A_W+B_W-1:0] prod_s1;

	// register every product
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign prod = prod_s1;

endmodule

// ----- src/crpi_checker.sv -----
// Port-level checks of the spline evaluator and their binding.
`include "assert_macros.svh"

module crpi_checker
	import crpi_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cmd_mode,
	input logic done
);

	// result strobe lasts one cycle
	`CRPI_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held longer than one cycle")
	// a load transfer never blocks the port
	`CRPI_ASSERT_NEXT(a_load_idle, start && !busy && cmd_mode == MODE_LOAD, !busy, "load transfer raised busy")
	// an evaluate transfer starts work at once
	`CRPI_ASSERT_NEXT(a_eval_busy, start && !busy && cmd_mode == MODE_EVAL, busy, "evaluate transfer did not raise busy")
	// every finished evaluation delivers a result
	`CRPI_ASSERT(a_end_result, $fell(busy) |-> done, "work ended without a result")

endmodule

bind catmull_rom_point_interpolator crpi_checker u_crpi_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.cmd_mode(cmd.mode),
	.done    (done)
);

// ----- tb/catmull_rom_point_interpolator_tb.sv -----
// Testbench of the Catmull-Rom point interpolator: directed table, random phases, spline checker.
`timescale 1ns / 1ps

module catmull_rom_point_interpolator_tb;
	import crpi_pkg::*;

	localparam int MAX_PTS   = 64;
	localparam int FRAC      = 16;
	localparam longint ONE   = longint'(1) << FRAC;
	localparam int SETTLE    = 60;
	localparam int DIR_ROWS  = 24;
	localparam int PHASES    = 15;
	localparam int PHASE_LEN = 40;

	typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_EVAL_CHK, ROW_CFG} row_kind_t;

	// One directed row; on ROW_EVAL_CHK the coordinates hold the expected point
	typedef struct packed {
		row_kind_t                 kind;
		logic [PIDX_W-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [T_W-1:0]            t;
		logic [CFG_W-1:0]          cnt;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	crpi_cmd_t        cmd;
	logic             done;
	crpi_result_t     result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Shadow copy of the point table and the count register
	logic signed [COORD_W-1:0] pt_tab [3][MAX_PTS];
	bit [MAX_PTS-1:0]          pt_loaded;
	logic [CFG_W-1:0]          point_cnt;

	crpi_result_t pending_pts[$];
	crpi_result_t want;
	int           mismatch_cnt;
	bit           no_idle;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{ROW_LOAD,     6'd0,  COORD_MIN,      COORD_MAX,      32'sh0001_8000, 17'd0,      7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MIN,      COORD_MAX,      32'sh0001_8000, 17'd0,      7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MIN,      COORD_MAX,      32'sh0001_8000, 17'h1FFFF,  7'd0},
		'{ROW_LOAD,     6'd1,  COORD_MAX,      COORD_MIN,      32'shFFFF_0000, 17'd0,      7'd0},
		'{ROW_CFG,      6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd0,      7'd2},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MIN,      COORD_MAX,      32'sh0001_8000, 17'd0,      7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MAX,      COORD_MIN,      32'shFFFF_0000, 17'd65536,  7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MAX,      COORD_MIN,      32'shFFFF_0000, 17'd65537,  7'd0},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd32768,  7'd0},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd1,      7'd0},
		'{ROW_LOAD,     6'd2,  COORD_MIN,      COORD_MAX,      32'sh7FFF_FFFF, 17'd0,      7'd0},
		'{ROW_LOAD,     6'd3,  COORD_MAX,      COORD_MIN,      32'sh8000_0000, 17'd0,      7'd0},
		'{ROW_CFG,      6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd0,      7'd4},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd21845,  7'd0},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd10923,  7'd0},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd43690,  7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MAX,      COORD_MIN,      32'sh8000_0000, 17'd65536,  7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MIN,      COORD_MAX,      32'sh0001_8000, 17'd0,      7'd0},
		'{ROW_LOAD,     6'd63, 32'sd1,         -32'sd1,        32'sd0,         17'd0,      7'd0},
		'{ROW_CFG,      6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd0,      7'd0},
		'{ROW_EVAL_CHK, 6'd0,  COORD_MIN,      COORD_MAX,      32'sh0001_8000, 17'd50000,  7'd0},
		'{ROW_CFG,      6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd0,      7'd3},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd65535,  7'd0},
		'{ROW_EVAL,     6'd0,  32'sd0,         32'sd0,         32'sd0,         17'd32768,  7'd0}
	};

	catmull_rom_point_interpolator #(
		.MAX_POINTS(MAX_PTS),
		.FRAC_BITS (FRAC)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Count in effect: zero acts as one, anything above the table size as the table size
	function automatic int active_points();
		int n;
		n = int'(point_cnt);
		if (n < 1) n = 1;
		if (n > MAX_PTS) n = MAX_PTS;
		return n;
	endfunction

	// One axis of the curve: Horner steps with round-half-up, halve, clip to 32 bits
	function automatic logic signed [COORD_W-1:0] spline_axis(input int ax, input int seg,
			input int n, input longint u, output bit clip);
		longint p0, p1, p2, p3, a, b, c, h, r;
		p1 = pt_tab[ax][seg];
		p2 = pt_tab[ax][seg + 1];
		if (seg > 0) p0 = pt_tab[ax][seg - 1];
		else p0 = 2 * p1 - p2;
		if (seg + 2 < n) p3 = pt_tab[ax][seg + 2];
		else p3 = 2 * p2 - p1;
		a = -p0 + 3 * p1 - 3 * p2 + p3;
		b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c = p2 - p0;
		h = ((a * u + (ONE >>> 1)) >>> FRAC) + b;
		h = ((h * u + (ONE >>> 1)) >>> FRAC) + c;
		h = ((h * u + (ONE >>> 1)) >>> FRAC) + 2 * p1;
		r = (h + 1) >>> 1;
		clip = 1'b0;
		if (r > longint'(COORD_MAX)) begin
			clip = 1'b1;
			r = longint'(COORD_MAX);
		end
		if (r < longint'(COORD_MIN)) begin
			clip = 1'b1;
			r = longint'(COORD_MIN);
		end
		return r[COORD_W-1:0];
	endfunction

	// Point on the curve for parameter t under the current table and count
	function automatic crpi_result_t spline_point(input logic [T_W-1:0] t_in);
		int n, seg;
		longint t, scaled, u;
		bit cx, cy, cz;
		crpi_result_t r;
		n = active_points();
		if (n == 1) begin
			r.out_x = pt_tab[0][0];
			r.out_y = pt_tab[1][0];
			r.out_z = pt_tab[2][0];
			r.saturated = 1'b0;
			return r;
		end
		t = t_in;
		if (t > ONE) t = ONE;
		scaled = t * (n - 1);
		seg = int'(scaled >>> FRAC);
		if (seg > n - 2) seg = n - 2;
		u = scaled - (longint'(seg) << FRAC);
		r.out_x = spline_axis(0, seg, n, u, cx);
		r.out_y = spline_axis(1, seg, n, u, cy);
		r.out_z = spline_axis(2, seg, n, u, cz);
		r.saturated = cx | cy | cz;
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [T_W-1:0] rand_t();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return T_W'(ONE);
			2: return T_W'($urandom_range(int'(ONE) + 1, (1 << T_W) - 1));
			default: return T_W'($urandom_range(0, int'(ONE)));
		endcase
	endfunction

	// Hold start until the transfer, then update the table or queue the expected point
	task automatic issue_cmd(input crpi_cmd_t c, input bit typed, input crpi_result_t given);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		if (c.mode == MODE_LOAD) begin
			pt_tab[0][c.point_index] = c.coord_x;
			pt_tab[1][c.point_index] = c.coord_y;
			pt_tab[2][c.point_index] = c.coord_z;
			pt_loaded[c.point_index] = 1'b1;
		end else if (typed) begin
			pending_pts.insert(pending_pts.size(), given);
		end else begin
			pending_pts.insert(pending_pts.size(), spline_point(c.param_t));
		end
	endtask

	// Drain, let the pipeline settle, then write the count register
	task automatic write_count(input logic [CFG_W-1:0] v);
		start <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		point_cnt = v;
	endtask

	// Check each result strobe against the oldest expected point
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pts.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
					result.out_x, result.out_y, result.out_z, result.saturated);
			end else begin
				want = pending_pts.pop_front();
				if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
						result.out_z !== want.out_z || result.saturated !== want.saturated) begin
					mismatch_cnt++;
					$display("%0t: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
						$time, want.out_x, want.out_y, want.out_z, want.saturated,
						result.out_x, result.out_y, result.out_z, result.saturated);
				end
			end
		end
	end

	// Stimulus: directed table, then random phases over a spread of counts
	initial begin
		crpi_cmd_t    c;
		crpi_result_t given;
		int           n, gap_slot;
		logic [CFG_W-1:0] phase_cnt [PHASES];

		phase_cnt = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd3, 7'd5, 7'd100,
			7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		point_cnt    = 7'd1;
		pt_loaded    = '0;
		mismatch_cnt = 0;
		no_idle      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_tab[i]) begin
			c = '0;
			c.coord_x = rand_coord();
			c.coord_y = rand_coord();
			c.coord_z = rand_coord();
			c.point_index = PIDX_W'($urandom);
			given = {dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, 1'b0};
			case (dir_tab[i].kind)
				ROW_CFG: begin
					write_count(dir_tab[i].cnt);
				end
				ROW_LOAD: begin
					c.mode        = MODE_LOAD;
					c.point_index = dir_tab[i].slot;
					c.coord_x     = dir_tab[i].x;
					c.coord_y     = dir_tab[i].y;
					c.coord_z     = dir_tab[i].z;
					issue_cmd(c, 1'b0, given);
				end
				default: begin
					c.mode    = MODE_EVAL;
					c.param_t = dir_tab[i].t;
					issue_cmd(c, dir_tab[i].kind == ROW_EVAL_CHK, given);
				end
			endcase
		end

		// random phases; the first few pin the extremes of the count
		for (int p = 0; p < PHASES; p++) begin
			if (p >= 8) phase_cnt[p] = CFG_W'($urandom);
			write_count(phase_cnt[p]);
			no_idle = ($urandom_range(0, 3) == 0);
			n = active_points();
			for (int k = 0; k < PHASE_LEN; k++) begin
				c.coord_x = rand_coord();
				c.coord_y = rand_coord();
				c.coord_z = rand_coord();
				c.param_t = rand_t();
				c.point_index = PIDX_W'($urandom_range(0, MAX_PTS - 1));
				// fill any slot the curve would read before evaluating
				gap_slot = -1;
				for (int s = n - 1; s >= 0; s--)
					if (!pt_loaded[s]) gap_slot = s;
				if (gap_slot >= 0) begin
					c.mode = MODE_LOAD;
					c.point_index = PIDX_W'(gap_slot);
				end else begin
					c.mode = ($urandom_range(0, 3) != 0) ? MODE_EVAL : MODE_LOAD;
				end
				issue_cmd(c, 1'b0, given);
			end
		end

		start <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[catmull_rom_point_interpolator] OK");
		else
			$display("[catmull_rom_point_interpolator] ERROR");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("[catmull_rom_point_interpolator] ERROR");
		$finish;
	end

endmodule
